// ----- design/rc4_stream_cipher_defines.svh -----
// Assertion helpers for the RC4 block. Both forms sample on the rising
// clock edge and are switched off while the reset is high.
`ifndef RC4_STREAM_CIPHER_DEFINES_SVH
`define RC4_STREAM_CIPHER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define RC4_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RC4_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define RC4_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define RC4_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ----- design/rc4_pkg.sv -----
`default_nettype none

package rc4_pkg;

  localparam int BYTE_W            = 8;
  localparam int SBOX_DEPTH        = 256;
  localparam int KEY_BYTES_DEFAULT = 8;
  localparam int REG_W             = 32;
  localparam int REG_ADDR_W        = 3;

  localparam logic [REG_W-1:0] KEY_LOW_RESET  = 32'hCAFE_BABE;
  localparam logic [REG_W-1:0] KEY_HIGH_RESET = 32'hDEAD_BEEF;

  typedef enum logic [0:0] {
    REG_KEY_LOW,
    REG_KEY_HIGH
  } reg_idx_t;

  // Microprogram steps, in program order.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_K1,
    ST_K2,
    ST_K3,
    ST_FILL,
    ST_S0,
    ST_S1,
    ST_S2,
    ST_S3,
    ST_END
  } step_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_GOTO,
    C_WAIT_ACC,
    C_WAIT_OUT,
    C_LOOP
  } cond_t;

  typedef enum logic [1:0] {
    RA_INC_I,
    RA_J_NEXT,
    RA_T,
    RA_CNT
  } raddr_sel_t;

  typedef enum logic [1:0] {
    WA_I,
    WA_J,
    WA_CNT
  } waddr_sel_t;

  typedef enum logic [1:0] {
    WD_CNT,
    WD_RD,
    WD_SI
  } wdata_sel_t;

  typedef enum logic [1:0] {
    I_HOLD,
    I_INC,
    I_CLR
  } i_op_t;

  typedef enum logic [1:0] {
    J_HOLD,
    J_KS,
    J_KEY,
    J_CLR
  } j_op_t;

  typedef enum logic [1:0] {
    K_HOLD,
    K_CLR,
    K_ADV
  } k_op_t;

  typedef struct packed {
    logic       ready;
    cond_t      cond;
    step_t      target;
    logic       re;
    raddr_sel_t raddr;
    logic       we;
    waddr_sel_t waddr;
    wdata_sel_t wdata;
    logic       ld_data;
    logic       ld_si;
    logic       ld_sj;
    logic       ld_out;
    logic       cnt_inc;
    logic       set_keyed;
    i_op_t      i_op;
    j_op_t      j_op;
    k_op_t      k_op;
  } ctrl_t;

  typedef struct packed {
    ctrl_t ctrl;
    logic  go;
  } seq_t;

  typedef struct packed {
    logic accept;
    logic need_key;
    logic cnt_last;
    logic out_free;
    logic keyed;
  } status_t;

  // Control store. One word per step; the sequencer gates every side
  // effect of a waiting step until its wait condition is met.
  function automatic ctrl_t microcode(step_t s);
    ctrl_t w;
    w = '0;
    unique case (s)
      ST_IDLE: begin
        w.ready   = 1'b1;
        w.cond    = C_WAIT_ACC;
        w.target  = ST_FILL;
        w.re      = 1'b1;
        w.raddr   = RA_INC_I;
        w.i_op    = I_INC;
        w.ld_data = 1'b1;
      end
      ST_K1: begin
        w.ld_si = 1'b1;
        w.j_op  = J_KS;
        w.re    = 1'b1;
        w.raddr = RA_J_NEXT;
      end
      ST_K2: begin
        w.ld_sj = 1'b1;
        w.we    = 1'b1;
        w.waddr = WA_I;
        w.wdata = WD_RD;
        w.re    = 1'b1;
        w.raddr = RA_T;
      end
      ST_K3: begin
        w.cond   = C_WAIT_OUT;
        w.target = ST_IDLE;
        w.we     = 1'b1;
        w.waddr  = WA_J;
        w.wdata  = WD_SI;
        w.ld_out = 1'b1;
      end
      ST_FILL: begin
        w.cond    = C_LOOP;
        w.target  = ST_FILL;
        w.we      = 1'b1;
        w.waddr   = WA_CNT;
        w.wdata   = WD_CNT;
        w.cnt_inc = 1'b1;
        w.i_op    = I_CLR;
        w.j_op    = J_CLR;
        w.k_op    = K_CLR;
      end
      ST_S0: begin
        w.re    = 1'b1;
        w.raddr = RA_CNT;
      end
      ST_S1: begin
        w.ld_si = 1'b1;
        w.j_op  = J_KEY;
        w.re    = 1'b1;
        w.raddr = RA_J_NEXT;
      end
      ST_S2: begin
        w.we    = 1'b1;
        w.waddr = WA_CNT;
        w.wdata = WD_RD;
      end
      ST_S3: begin
        w.cond    = C_LOOP;
        w.target  = ST_S0;
        w.we      = 1'b1;
        w.waddr   = WA_J;
        w.wdata   = WD_SI;
        w.cnt_inc = 1'b1;
        w.k_op    = K_ADV;
      end
      ST_END: begin
        w.cond      = C_GOTO;
        w.target    = ST_K1;
        w.re        = 1'b1;
        w.raddr     = RA_INC_I;
        w.i_op      = I_INC;
        w.j_op      = J_CLR;
        w.set_keyed = 1'b1;
      end
      default: begin
        w.cond   = C_GOTO;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- design/rc4_channels.sv -----
`default_nettype none

interface rc4_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_message;

  modport source (output valid, output data_byte, output new_message, input ready);
  modport sink   (input valid, input data_byte, input new_message, output ready);
endinterface

interface rc4_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_byte;

  modport source (output valid, output result_byte, input ready);
  modport sink   (input valid, input result_byte, output ready);
endinterface

`default_nettype wire

// ----- design/rc4_stream_cipher.sv -----
// RC4 stream cipher, one byte per beat.
// The item channel carries data_byte and new_message; the result channel
// returns data_byte XOR the next keystream byte, one result per item, in order.
// The 64-bit key sits in two APB registers, key_low at 0x0 and key_high at 0x4,
// key byte 0 in the low byte of key_low; KEY_BYTES sets how many are cycled.
// A key change takes effect at the next message start.
// A beat with new_message set reruns the key schedule first: an identity fill
// of all 256 entries, a shuffle pass over every entry and a setup step.
// A keyed byte then runs steps K1 to K3, its result registered in K3; no new
// byte is taken until the block is back in idle, as the S-box RAM (one read
// and one write port) needs three dependent reads and two writes per byte.
// After reset the keys hold their defaults and the first beat always runs the
// key schedule. When the receiver stalls, the result holds in the output
// register; the next byte is still accepted and worked on, and waits in its
// last step until the output register frees.
`default_nettype none
`include "rc4_stream_cipher_defines.svh"

module rc4_stream_cipher
  import rc4_pkg::*;
#(
  parameter int KEY_BYTES = KEY_BYTES_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [REG_ADDR_W-1:0] paddr,
  input  wire logic [REG_W-1:0]      pwdata,
  output logic      [REG_W-1:0]      prdata,
  output logic                       pready,
  rc4_in_if.sink                     item,
  rc4_out_if.source                  result
);

  logic [REG_W-1:0] key_low;
  logic [REG_W-1:0] key_high;
  reg_idx_t         reg_idx;
  logic             cfg_write;
  logic             accept;
  seq_t             seq;
  status_t          status;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= KEY_LOW_RESET;
      key_high <= KEY_HIGH_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_KEY_LOW:  key_low  <= pwdata;
        REG_KEY_HIGH: key_high <= pwdata;
        default:      key_low  <= key_low;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_KEY_LOW:  prdata = key_low;
      REG_KEY_HIGH: prdata = key_high;
      default:      prdata = key_low;
    endcase
  end

  assign item.ready = seq.ctrl.ready;
  assign accept     = item.valid && item.ready;

  rc4_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .seq    (seq)
  );

  rc4_dp #(
    .KEY_BYTES (KEY_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .seq         (seq),
    .key_low     (key_low),
    .key_high    (key_high),
    .data_byte   (item.data_byte),
    .new_message (item.new_message),
    .accept      (accept),
    .out_ready   (result.ready),
    .out_valid   (result.valid),
    .result_byte (result.result_byte),
    .status      (status)
  );

  `RC4_ASSERT_NXT(a_busy_after_accept, clk, rst, accept, !item.ready, "item ready right after an accepted beat")
  `RC4_ASSERT_IMP(a_out_free_on_load, clk, rst, seq.go && seq.ctrl.ld_out, !result.valid || result.ready, "result register overwritten while held")
  `RC4_ASSERT_NXT(a_keyed_sticky, clk, rst, status.keyed, status.keyed, "keyed flag dropped outside reset")

endmodule

`default_nettype wire

// ----- design/rc4_ram.sv -----
`default_nettype none

module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/rc4_seq.sv -----
`default_nettype none

module rc4_seq
  import rc4_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire status_t status,
  output seq_t         seq
);

  step_t step;
  step_t step_next;
  step_t step_inc;

  assign step_inc = step_t'(step + 4'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // Next step.
  always_comb begin
    step_next = step;
    unique case (seq.ctrl.cond)
      C_NEXT: step_next = step_inc;
      C_GOTO: step_next = seq.ctrl.target;
      C_WAIT_ACC: begin
        if (status.accept) begin
          step_next = status.need_key ? seq.ctrl.target : step_inc;
        end
      end
      C_WAIT_OUT: begin
        if (status.out_free) begin
          step_next = seq.ctrl.target;
        end
      end
      C_LOOP: step_next = status.cnt_last ? step_inc : seq.ctrl.target;
      default: step_next = ST_IDLE;
    endcase
  end

  // Control word and the strobe that releases its side effects.
  always_comb begin
    seq.ctrl = microcode(step);
    unique case (seq.ctrl.cond)
      C_WAIT_ACC: seq.go = status.accept;
      C_WAIT_OUT: seq.go = status.out_free;
      default:    seq.go = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/rc4_dp.sv -----
`default_nettype none

module rc4_dp
  import rc4_pkg::*;
#(
  parameter int KEY_BYTES = KEY_BYTES_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire seq_t              seq,
  input  wire logic [REG_W-1:0]  key_low,
  input  wire logic [REG_W-1:0]  key_high,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic              new_message,
  input  wire logic              accept,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic      [BYTE_W-1:0] result_byte,
  output status_t                status
);

  localparam int KEY_N  = (KEY_BYTES < 1) ? 1 : ((KEY_BYTES > 8) ? 8 : KEY_BYTES);
  localparam int KIDX_W = (KEY_N > 1) ? $clog2(KEY_N) : 1;

  ctrl_t c;
  logic  fire;

  logic [BYTE_W-1:0] idx_i;
  logic [BYTE_W-1:0] idx_j;
  logic [BYTE_W-1:0] j_next;
  logic [BYTE_W-1:0] cnt;
  logic [KIDX_W-1:0] kidx;
  logic              keyed;
  logic [BYTE_W-1:0] si;
  logic [BYTE_W-1:0] sj;
  logic [BYTE_W-1:0] t_idx;
  logic [BYTE_W-1:0] data;
  logic [BYTE_W-1:0] rd;
  logic [BYTE_W-1:0] raddr;
  logic [BYTE_W-1:0] waddr;
  logic [BYTE_W-1:0] wdata;
  logic [BYTE_W-1:0] key_sel;
  logic [BYTE_W-1:0] ks;
  logic [2*REG_W-1:0] key_word;

  assign c    = seq.ctrl;
  assign fire = seq.go;

  assign key_word = {key_high, key_low};
  assign key_sel  = key_word[{kidx, 3'b000} +: BYTE_W];

  always_comb begin
    unique case (c.j_op)
      J_HOLD:  j_next = idx_j;
      J_KS:    j_next = idx_j + rd;
      J_KEY:   j_next = idx_j + rd + key_sel;
      J_CLR:   j_next = '0;
      default: j_next = idx_j;
    endcase
  end

  always_comb begin
    unique case (c.raddr)
      RA_INC_I:  raddr = idx_i + 8'd1;
      RA_J_NEXT: raddr = j_next;
      RA_T:      raddr = si + rd;
      RA_CNT:    raddr = cnt;
      default:   raddr = cnt;
    endcase
  end

  always_comb begin
    unique case (c.waddr)
      WA_I:    waddr = idx_i;
      WA_J:    waddr = idx_j;
      WA_CNT:  waddr = cnt;
      default: waddr = cnt;
    endcase
  end

  always_comb begin
    unique case (c.wdata)
      WD_CNT:  wdata = cnt;
      WD_RD:   wdata = rd;
      WD_SI:   wdata = si;
      default: wdata = rd;
    endcase
  end

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (SBOX_DEPTH)
  ) u_sbox (
    .clk   (clk),
    .we    (c.we && fire),
    .waddr (waddr),
    .wdata (wdata),
    .re    (c.re && fire),
    .raddr (raddr),
    .rdata (rd)
  );

  // The keystream read was issued in the same cycle as the write to S[i],
  // and S[j] is written only now, so both swapped entries are forwarded.
  always_comb begin
    if (t_idx == idx_j) begin
      ks = si;
    end else if (t_idx == idx_i) begin
      ks = sj;
    end else begin
      ks = rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx_i     <= '0;
      idx_j     <= '0;
      cnt       <= '0;
      kidx      <= '0;
      keyed     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        unique case (c.i_op)
          I_INC:   idx_i <= idx_i + 8'd1;
          I_CLR:   idx_i <= '0;
          default: idx_i <= idx_i;
        endcase
        idx_j <= j_next;
        if (c.cnt_inc) begin
          cnt <= cnt + 8'd1;
        end
        unique case (c.k_op)
          K_CLR: kidx <= '0;
          K_ADV: begin
            if (kidx == KIDX_W'(KEY_N - 1)) begin
              kidx <= '0;
            end else begin
              kidx <= kidx + KIDX_W'(1);
            end
          end
          default: kidx <= kidx;
        endcase
        if (c.set_keyed) begin
          keyed <= 1'b1;
        end
      end
      if (fire && c.ld_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (c.ld_data) begin
        data <= data_byte;
      end
      if (c.ld_si) begin
        si <= rd;
      end
      if (c.ld_sj) begin
        sj    <= rd;
        t_idx <= si + rd;
      end
      if (c.ld_out) begin
        result_byte <= data ^ ks;
      end
    end
  end

  assign status.accept   = accept;
  assign status.need_key = new_message || !keyed;
  assign status.cnt_last = (cnt == BYTE_W'(SBOX_DEPTH - 1));
  assign status.out_free = !out_valid || out_ready;
  assign status.keyed    = keyed;

endmodule

`default_nettype wire

// ----- test/tb_rc4_stream_cipher.sv -----
`default_nettype none

module tb_rc4_stream_cipher;
  import rc4_pkg::*;

  localparam int KEY_LEN        = KEY_BYTES_DEFAULT;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int RANDOM_BYTES   = 1500;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [REG_ADDR_W-1:0] paddr;
  logic [REG_W-1:0]      pwdata;
  logic [REG_W-1:0]      prdata;
  logic                  pready;

  rc4_in_if  in_ch ();
  rc4_out_if out_ch ();

  rc4_stream_cipher dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .item    (in_ch),
    .result  (out_ch)
  );

  always #5 clk = ~clk;

  // Cipher state as the testbench sees it.
  logic [7:0]  perm [SBOX_DEPTH];
  logic [7:0]  idx_i;
  logic [7:0]  idx_j;
  logic        keyed;
  logic [31:0] key_lo;
  logic [31:0] key_hi;

  logic [7:0] pending_bytes [$];
  logic [7:0] want_byte;

  int errors        = 0;
  int bytes_checked = 0;
  int schedules     = 0;
  int key_writes    = 0;
  int burst_left    = 0;
  int idle_cycles   = 0;
  int stall_left    = 0;
  int ready_cycle   = 0;

  function automatic void rekey_sbox();
    logic [63:0] whole;
    logic [7:0]  acc;
    logic [7:0]  t;
    int          n;
    whole = {key_hi, key_lo};
    for (n = 0; n < SBOX_DEPTH; n++) perm[n] = 8'(n);
    acc = 8'h00;
    for (n = 0; n < SBOX_DEPTH; n++) begin
      acc = acc + perm[n] + whole[8*(n % KEY_LEN) +: 8];
      t = perm[n];
      perm[n] = perm[acc];
      perm[acc] = t;
    end
    idx_i = 8'h00;
    idx_j = 8'h00;
    keyed = 1'b1;
  endfunction

  function automatic logic [7:0] cipher_next(input logic [7:0] d, input logic start);
    logic [7:0] t;
    logic [7:0] pick;
    if (start || !keyed) rekey_sbox();
    idx_i = idx_i + 8'd1;
    idx_j = idx_j + perm[idx_i];
    t = perm[idx_i];
    perm[idx_i] = perm[idx_j];
    perm[idx_j] = t;
    pick = perm[idx_i] + perm[idx_j];
    return d ^ perm[pick];
  endfunction

  function automatic logic [31:0] random_key();
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    errors++;
    if (errors <= 10)
      $display("mismatch on %s: expected %h, got %h at %0t", what, want, got, $time);
  endtask

  // Result side: check each beat, then stall on a pattern that alternates
  // calm stretches with bursts of random stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_bytes.size() == 0) begin
          errors++;
          if (errors <= 10) $display("result beat %h with nothing expected at %0t",
                                     out_ch.result_byte, $time);
        end else begin
          want_byte = pending_bytes.pop_front();
          bytes_checked++;
          if (out_ch.result_byte !== want_byte)
            report_mismatch("result_byte", 32'(want_byte), 32'(out_ch.result_byte));
        end
      end
      ready_cycle++;
      if (ready_cycle[9]) begin
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 15);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("no beat accepted for %0d cycles, %0d results outstanding",
                 idle_cycles, pending_bytes.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // Sends one byte; the sender runs in bursts with random gaps in between.
  task automatic send_byte(input logic [7:0] d, input logic start);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= d;
    in_ch.new_message <= start;
    do @(posedge clk); while (!in_ch.ready);
    if (start || !keyed) schedules++;
    pending_bytes.push_back(cipher_next(d, start));
    burst_left--;
  endtask

  // Holds the sender off until every result is back and the block is idle.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes a key register and reads it back in the same bus transfer sequence.
  task automatic write_key(input reg_idx_t r, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_ADDR_W'(4 * int'(r));
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (r == REG_KEY_LOW) key_lo = v;
    else key_hi = v;
    key_writes++;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== v)
      report_mismatch((r == REG_KEY_LOW) ? "key_low readback" : "key_high readback",
                      v, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // The first byte after reset must run the key schedule even without the flag.
  task automatic test_first_byte_after_reset();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
  endtask

  task automatic test_key_extremes();
    logic [31:0] lows  [4];
    logic [31:0] highs [4];
    int          n;
    lows[0] = 32'h0000_0000; highs[0] = 32'h0000_0000;
    lows[1] = 32'hFFFF_FFFF; highs[1] = 32'hFFFF_FFFF;
    lows[2] = 32'h0000_0000; highs[2] = 32'hFFFF_FFFF;
    lows[3] = 32'h0123_4567; highs[3] = 32'h89AB_CDEF;
    for (n = 0; n < 4; n++) begin
      wait_idle();
      write_key(REG_KEY_LOW, lows[n]);
      write_key(REG_KEY_HIGH, highs[n]);
      send_byte(8'($urandom), 1'b1);
      send_byte(8'($urandom), 1'b0);
      send_byte(8'($urandom), 1'b0);
    end
  endtask

  // A new key must leave the running keystream alone until the next message.
  task automatic test_key_change_mid_message();
    wait_idle();
    write_key(REG_KEY_LOW, random_key());
    write_key(REG_KEY_HIGH, random_key());
    send_byte(8'($urandom), 1'b1);
    send_byte(8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b0);
    wait_idle();
    write_key(REG_KEY_LOW, $urandom);
    write_key(REG_KEY_HIGH, $urandom);
    send_byte(8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b1);
  endtask

  // Mostly well-formed messages of random length; a few restart mid-stream
  // and a few carry on without a start flag.
  task automatic test_random_traffic(input int total);
    int   sent;
    int   len;
    int   n;
    logic start;
    sent = 0;
    while (sent < total) begin
      if ($urandom_range(0, 5) == 0) begin
        wait_idle();
        write_key(REG_KEY_LOW, random_key());
        write_key(REG_KEY_HIGH, random_key());
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
      for (n = 0; n < len && sent < total; n++) begin
        start = (n == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
        send_byte(8'($urandom), start);
        sent++;
      end
    end
  endtask

  initial begin
    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.data_byte   <= 8'h00;
    in_ch.new_message <= 1'b0;
    key_lo = KEY_LOW_RESET;
    key_hi = KEY_HIGH_RESET;
    idx_i  = 8'h00;
    idx_j  = 8'h00;
    keyed  = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_first_byte_after_reset();
    test_key_extremes();
    test_key_change_mid_message();
    test_random_traffic(RANDOM_BYTES);
    wait_idle();

    $display("checked %0d result bytes over %0d key schedules and %0d key writes,",
             bytes_checked, schedules, key_writes);
    $display("with sender gaps, receiver stalls and key changes between messages");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
